FILE: src/utf8_text_sanitizer_top_assert.svh
// Assertion macros shared by the sanitizer modules.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef UTF8_TEXT_SANITIZER_TOP_ASSERT_SVH
`define UTF8_TEXT_SANITIZER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UTSAN_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UTSAN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/utsan_pkg.sv
package utsan_pkg;

    localparam logic [7:0] SPACE_BYTE = 8'h20;
    localparam int unsigned MAX_RESULTS = 4;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [2:0]                  count;
        logic                        eot;
    } result_group_t;

    function automatic logic is_allowed(input logic [20:0] cp);
        is_allowed = (cp == 21'h09) || (cp == 21'h0A) || (cp == 21'h0D) ||
                     (cp >= 21'h20 && cp <= 21'h7E) ||
                     (cp >= 21'hA0 && cp <= 21'hFF) ||
                     (cp >= 21'h3000 && cp <= 21'h303F) ||
                     (cp >= 21'h3400 && cp <= 21'h4DBF) ||
                     (cp >= 21'h4E00 && cp <= 21'h9FFF) ||
                     (cp >= 21'hFF00 && cp <= 21'hFFEF);
    endfunction

endpackage

FILE: src/utsan_in_if.sv
interface utsan_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_text;

    modport source (output valid, output in_byte, output end_of_text, input ready);
    modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

FILE: src/utsan_out_if.sv
interface utsan_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_end;

    modport source (output valid, output out_byte, output run_last, output text_end,
                    input ready);
    modport sink (input valid, input out_byte, input run_last, input text_end,
                  output ready);
endinterface

FILE: src/utsan_decode.sv
`include "utf8_text_sanitizer_top_assert.svh"

module utsan_decode (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     advance,
    input  logic [7:0]               in_byte,
    input  logic                     end_of_text,
    output utsan_pkg::result_group_t group
);

    localparam logic [7:0] LEAD_E0 = 8'hE0;
    localparam logic [7:0] LEAD_ED = 8'hED;
    localparam logic [7:0] LEAD_F0 = 8'hF0;
    localparam logic [7:0] LEAD_F4 = 8'hF4;

    logic [2:0][7:0] pend_reg;
    logic [2:0][7:0] pend_next;
    logic [1:0]      pcnt_reg;
    logic [1:0]      pcnt_next;
    logic [2:0]      slen_reg;
    logic [2:0]      slen_next;
    logic [20:0]     pcp_reg;
    logic [20:0]     pcp_next;

    logic [2:0]      lead_len;
    logic [20:0]     lead_bits;
    logic [7:0]      lead_out;
    logic [7:0]      cont_lo;
    logic [7:0]      cont_hi;
    logic            cont_ok;
    logic [20:0]     cp_ext;
    logic [2:0]      pcnt_ext;
    logic            complete;
    logic            seq_open;
    logic [1:0]      base;
    logic [2:0]      base_ext;

    assign seq_open = (slen_reg != 3'd0);
    assign pcnt_ext = {1'b0, pcnt_reg};
    assign complete = ((pcnt_ext + 3'd1) >= slen_reg);
    assign cp_ext   = {pcp_reg[14:0], in_byte[5:0]};
    assign base     = seq_open ? pcnt_reg : 2'd0;
    assign base_ext = {1'b0, base};
    assign lead_out = (!in_byte[7] && utsan_pkg::is_allowed({13'd0, in_byte}))
                      ? in_byte : utsan_pkg::SPACE_BYTE;
    assign cont_ok  = (in_byte >= cont_lo) && (in_byte <= cont_hi);

    always_comb
    begin
        lead_len  = 3'd0;
        lead_bits = '0;
        if (in_byte >= 8'hC2 && in_byte <= 8'hDF)
        begin
            lead_len  = 3'd2;
            lead_bits = {16'd0, in_byte[4:0]};
        end
        else if (in_byte >= 8'hE0 && in_byte <= 8'hEF)
        begin
            lead_len  = 3'd3;
            lead_bits = {17'd0, in_byte[3:0]};
        end
        else if (in_byte >= 8'hF0 && in_byte <= 8'hF4)
        begin
            lead_len  = 3'd4;
            lead_bits = {18'd0, in_byte[2:0]};
        end
    end

    // The second byte of some sequences has a narrower range, which rules out
    // overlong forms, surrogates and code points above the Unicode limit.
    always_comb
    begin
        cont_lo = 8'h80;
        cont_hi = 8'hBF;
        if (pcnt_reg == 2'd1)
        begin
            case (pend_reg[0])
                LEAD_E0: cont_lo = 8'hA0;
                LEAD_ED: cont_hi = 8'h9F;
                LEAD_F0: cont_lo = 8'h90;
                LEAD_F4: cont_hi = 8'h8F;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        group.bytes = {utsan_pkg::MAX_RESULTS{utsan_pkg::SPACE_BYTE}};
        group.count = 3'd0;
        group.eot   = end_of_text;
        pend_next   = pend_reg;
        pcnt_next   = pcnt_reg;
        slen_next   = slen_reg;
        pcp_next    = pcp_reg;

        if (seq_open && cont_ok)
        begin
            if (complete)
            begin
                if (utsan_pkg::is_allowed(cp_ext))
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        if (2'(i) < pcnt_reg)
                        begin
                            group.bytes[2'(i)] = pend_reg[2'(i)];
                        end
                    end
                    group.bytes[pcnt_reg] = in_byte;
                    group.count           = pcnt_ext + 3'd1;
                end
                else
                begin
                    group.count = 3'd1;
                end
                pend_next = '0;
                pcnt_next = 2'd0;
                slen_next = 3'd0;
                pcp_next  = '0;
            end
            else
            begin
                if (pcnt_reg[0])
                begin
                    pend_next[1] = in_byte;
                end
                else
                begin
                    pend_next[2] = in_byte;
                end
                pcnt_next = pcnt_reg + 2'd1;
                pcp_next  = cp_ext;
                if (end_of_text)
                begin
                    group.count = pcnt_ext + 3'd1;
                    pend_next   = '0;
                    pcnt_next   = 2'd0;
                    slen_next   = 3'd0;
                    pcp_next    = '0;
                end
            end
        end
        else
        begin
            // Any buffered bytes become spaces, then the byte starts afresh.
            if (lead_len == 3'd0)
            begin
                group.bytes[base] = lead_out;
                group.count       = base_ext + 3'd1;
                pend_next         = '0;
                pcnt_next         = 2'd0;
                slen_next         = 3'd0;
                pcp_next          = '0;
            end
            else
            begin
                pend_next    = '0;
                pend_next[0] = in_byte;
                pcnt_next    = 2'd1;
                slen_next    = lead_len;
                pcp_next     = lead_bits;
                group.count  = base_ext;
                if (end_of_text)
                begin
                    group.count = base_ext + 3'd1;
                    pend_next   = '0;
                    pcnt_next   = 2'd0;
                    slen_next   = 3'd0;
                    pcp_next    = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            pcnt_reg <= 2'd0;
            slen_reg <= 3'd0;
            pcp_reg  <= '0;
        end
        else if (advance)
        begin
            pend_reg <= pend_next;
            pcnt_reg <= pcnt_next;
            slen_reg <= slen_next;
            pcp_reg  <= pcp_next;
        end
    end

    `UTSAN_ASSERT_NOW(a_open_count, seq_open,
        (pcnt_reg != 2'd0) && (pcnt_ext < slen_reg),
        "open sequence holds a bad byte count")
    `UTSAN_ASSERT_NOW(a_closed_empty, !seq_open, pcnt_reg == 2'd0,
        "closed sequence still holds bytes")
    `UTSAN_ASSERT_NEXT(a_eot_closes, advance && end_of_text, slen_reg == 3'd0,
        "sequence left open after end of text")

endmodule

FILE: src/utsan_outbuf.sv
`include "utf8_text_sanitizer_top_assert.svh"

module utsan_outbuf (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  utsan_pkg::result_group_t group,
    output logic                     can_load,
    utsan_out_if.source              result
);

    logic [utsan_pkg::MAX_RESULTS-1:0][7:0] bytes_reg;
    logic [2:0]                             cnt_reg;
    logic                                   eot_reg;
    logic                                   pop;

    assign result.valid    = (cnt_reg != 3'd0);
    assign result.out_byte = bytes_reg[0];
    assign result.run_last = (cnt_reg == 3'd1);
    assign result.text_end = (cnt_reg == 3'd1) && eot_reg;
    assign pop             = result.valid && result.ready;
    assign can_load        = (cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && result.ready);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bytes_reg <= group.bytes;
        end
        else if (pop)
        begin
            bytes_reg <= {utsan_pkg::SPACE_BYTE, bytes_reg[utsan_pkg::MAX_RESULTS-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 3'd0;
            eot_reg <= 1'b0;
        end
        else if (load)
        begin
            cnt_reg <= group.count;
            eot_reg <= group.eot;
        end
        else if (pop)
        begin
            cnt_reg <= cnt_reg - 3'd1;
        end
    end

    `UTSAN_ASSERT_NOW(a_cnt_range, 1'b1, cnt_reg <= 3'd4, "result count out of range")
    `UTSAN_ASSERT_NOW(a_load_free, load, can_load && (group.count != 3'd0),
        "results loaded over a busy buffer")
    `UTSAN_ASSERT_NEXT(a_pop_drain, pop && !load, cnt_reg == $past(cnt_reg) - 3'd1,
        "result count did not drain")

endmodule

FILE: src/utf8_text_sanitizer_top.sv
// Channel   Interface      Role    Payload
// text      utsan_in_if    sink    in_byte[7:0], end_of_text
// result    utsan_out_if   source  out_byte[7:0], run_last, text_end
//
// One input byte per cycle while result.ready stays high; a byte that causes k
// results holds the input register until the result buffer, which sends one byte
// per cycle, can take them. Each byte passes the input register, then the result buffer.
// Reset clears the open sequence and empties both registers.
// Stalls on the result side fill the input register and then drop text.ready.
module utf8_text_sanitizer_top (
    input  logic       clk,
    input  logic       rst_n,
    utsan_in_if.sink   text,
    utsan_out_if.source result
);

    logic                     in_vld_reg;
    logic [7:0]               in_byte_reg;
    logic                     in_eot_reg;
    logic                     advance;
    logic                     load;
    logic                     can_load;
    utsan_pkg::result_group_t group;

    assign advance    = in_vld_reg && ((group.count == 3'd0) || can_load);
    assign load       = advance && (group.count != 3'd0);
    assign text.ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (text.ready)
        begin
            in_vld_reg <= text.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text.ready && text.valid)
        begin
            in_byte_reg <= text.in_byte;
            in_eot_reg  <= text.end_of_text;
        end
    end

    utsan_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .in_byte     (in_byte_reg),
        .end_of_text (in_eot_reg),
        .group       (group)
    );

    utsan_outbuf u_outbuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .group    (group),
        .can_load (can_load),
        .result   (result)
    );

endmodule

FILE: bench/tb.sv
module tb;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       text_end;
    } clean_byte_t;

    typedef struct {
        logic [7:0] data;
        logic       eot;
        int         gap;
        bit         drain;
    } text_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    utsan_in_if  text ();
    utsan_out_if result ();

    logic       send_valid = 1'b0;
    logic [7:0] send_byte = 8'h00;
    logic       send_eot = 1'b0;
    logic       take_ready = 1'b0;

    assign text.valid       = send_valid;
    assign text.in_byte     = send_byte;
    assign text.end_of_text = send_eot;
    assign result.ready     = take_ready;

    utf8_text_sanitizer_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text),
        .result (result)
    );

    always #5 clk = ~clk;

    text_item_t  text_q[$];
    clean_byte_t cleaned_q[$];
    int          item_total;
    int          error_count = 0;
    int          items_accepted = 0;
    logic        results_drained = 1'b1;
    logic        hold_off = 1'b0;

    // Decoder state of the open sequence.
    logic [7:0]  seq_bytes [3];
    logic [1:0]  seq_held;
    logic [2:0]  seq_len;
    logic [20:0] seq_cp;
    logic [7:0]  step_out [4];
    int          step_n;

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $time, what);
        error_count++;
    endtask

    function automatic bit cp_kept(input logic [20:0] cp);
        if (cp == 21'h09 || cp == 21'h0A || cp == 21'h0D)
            return 1'b1;
        if (cp < 21'h20 || cp == 21'h7F)
            return 1'b0;
        if (cp < 21'h80)
            return 1'b1;
        if (cp < 21'hA0)
            return 1'b0;
        if (cp <= 21'hFF)
            return 1'b1;
        return (cp >= 21'h3000 && cp <= 21'h303F) ||
               (cp >= 21'h3400 && cp <= 21'h4DBF) ||
               (cp >= 21'h4E00 && cp <= 21'h9FFF) ||
               (cp >= 21'hFF00 && cp <= 21'hFFEF);
    endfunction

    function automatic void emit_clean(input logic [7:0] b);
        if (step_n < 4)
        begin
            step_out[step_n] = b;
            step_n++;
        end
    endfunction

    function automatic void close_seq();
        seq_bytes[0] = 8'h00;
        seq_bytes[1] = 8'h00;
        seq_bytes[2] = 8'h00;
        seq_held = 2'd0;
        seq_len = 3'd0;
        seq_cp = 21'd0;
    endfunction

    function automatic void flush_held();
        int i;
        for (i = 0; i < int'(seq_held); i++)
            emit_clean(utsan_pkg::SPACE_BYTE);
        close_seq();
    endfunction

    function automatic void take_lead(input logic [7:0] b);
        if (b < 8'h80)
            emit_clean(cp_kept({13'd0, b}) ? b : utsan_pkg::SPACE_BYTE);
        else if (b >= 8'hC2 && b <= 8'hDF)
        begin
            seq_bytes[0] = b;
            seq_held = 2'd1;
            seq_len = 3'd2;
            seq_cp = {16'd0, b[4:0]};
        end
        else if (b >= 8'hE0 && b <= 8'hEF)
        begin
            seq_bytes[0] = b;
            seq_held = 2'd1;
            seq_len = 3'd3;
            seq_cp = {17'd0, b[3:0]};
        end
        else if (b >= 8'hF0 && b <= 8'hF4)
        begin
            seq_bytes[0] = b;
            seq_held = 2'd1;
            seq_len = 3'd4;
            seq_cp = {18'd0, b[2:0]};
        end
        else
            emit_clean(utsan_pkg::SPACE_BYTE);
    endfunction

    task automatic predict_clean(input logic [7:0] b, input logic eot);
        logic [7:0]  lo;
        logic [7:0]  hi;
        clean_byte_t c;
        int          i;
        step_n = 0;
        if (seq_len != 3'd0)
        begin
            lo = 8'h80;
            hi = 8'hBF;
            if (seq_held == 2'd1)
            begin
                case (seq_bytes[0])
                    8'hE0: lo = 8'hA0;
                    8'hED: hi = 8'h9F;
                    8'hF0: lo = 8'h90;
                    8'hF4: hi = 8'h8F;
                    default: ;
                endcase
            end
            if (b >= lo && b <= hi)
            begin
                seq_cp = {seq_cp[14:0], b[5:0]};
                if (int'(seq_held) + 1 >= int'(seq_len))
                begin
                    if (cp_kept(seq_cp))
                    begin
                        for (i = 0; i < int'(seq_held); i++)
                            emit_clean(seq_bytes[i]);
                        emit_clean(b);
                    end
                    else
                        emit_clean(utsan_pkg::SPACE_BYTE);
                    close_seq();
                end
                else
                begin
                    seq_bytes[seq_held] = b;
                    seq_held = seq_held + 2'd1;
                end
            end
            else
            begin
                flush_held();
                take_lead(b);
            end
        end
        else
            take_lead(b);
        if (eot && seq_len != 3'd0)
            flush_held();
        for (i = 0; i < step_n; i++)
        begin
            c.out_byte = step_out[i];
            c.run_last = (i == step_n - 1);
            c.text_end = (i == step_n - 1) && eot;
            cleaned_q.insert(cleaned_q.size(), c);
        end
    endtask

    task automatic add_text_byte(input logic [7:0] data, input logic eot);
        text_item_t it;
        int         idx;
        idx = text_q.size();
        it.data = data;
        it.eot = eot;
        it.gap = ((idx / 60) % 4 == 1) ? 0 : $urandom_range(0, 18);
        it.drain = (idx == 200 || idx == 400);
        text_q.insert(text_q.size(), it);
    endtask

    function automatic logic rand_eot();
        return ($urandom_range(0, 24) == 0);
    endfunction

    function automatic logic [20:0] pick_codepoint();
        logic [20:0] edges [33];
        logic [20:0] cp;
        edges = '{21'h08, 21'h09, 21'h0A, 21'h0B, 21'h0D, 21'h0E, 21'h1F, 21'h20,
                  21'h7E, 21'h7F, 21'h9F, 21'hA0, 21'hFF, 21'h100, 21'h2FFF, 21'h3000,
                  21'h303F, 21'h3040, 21'h33FF, 21'h3400, 21'h4DBF, 21'h4DC0, 21'h4DFF,
                  21'h4E00, 21'h9FFF, 21'hA000, 21'hFEFF, 21'hFF00, 21'hFFEF, 21'hFFF0,
                  21'hFFFF, 21'h10000, 21'h10FFFF};
        case ($urandom_range(0, 8))
            0: cp = 21'($urandom_range(0, 'h7F));
            1: cp = 21'($urandom_range('h80, 'h7FF));
            2: cp = 21'($urandom_range('h3000, 'h303F));
            3: cp = 21'($urandom_range('h3400, 'h4DBF));
            4: cp = 21'($urandom_range('h4E00, 'h9FFF));
            5: cp = 21'($urandom_range('hFF00, 'hFFEF));
            6: cp = 21'($urandom_range('h800, 'hFFFF));
            7: cp = 21'($urandom_range('h10000, 'h10FFFF));
            default: cp = edges[$urandom_range(0, 32)];
        endcase
        if (cp >= 21'hD800 && cp <= 21'hDFFF)
            cp = cp ^ 21'h2000;
        return cp;
    endfunction

    task automatic add_codepoint(input logic [20:0] cp, input int cut, input int spoil);
        logic [7:0] enc [4];
        int         len;
        int         i;
        if (cp < 21'h80)
        begin
            len = 1;
            enc[0] = cp[7:0];
        end
        else if (cp < 21'h800)
        begin
            len = 2;
            enc[0] = {3'b110, cp[10:6]};
        end
        else if (cp < 21'h10000)
        begin
            len = 3;
            enc[0] = {4'b1110, cp[15:12]};
        end
        else
        begin
            len = 4;
            enc[0] = {5'b11110, cp[20:18]};
        end
        enc[1] = {2'b10, (len == 2) ? cp[5:0] : (len == 3) ? cp[11:6] : cp[17:12]};
        enc[2] = {2'b10, (len == 3) ? cp[5:0] : cp[11:6]};
        enc[3] = {2'b10, cp[5:0]};
        if (spoil > 0 && spoil < len)
            enc[spoil] = 8'($urandom_range(0, 255));
        if (cut > 0 && cut < len)
            len = cut;
        for (i = 0; i < len; i++)
            add_text_byte(enc[i], rand_eot());
    endtask

    // Sender: one pending transaction at a time, with a drawn gap before it is offered.
    text_item_t cur_item = '{8'h00, 1'b0, 0, 1'b0};
    logic       have_item = 1'b0;
    logic       drain_wait = 1'b0;
    logic       just_popped;
    logic       offer;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            send_valid <= 1'b0;
            have_item = 1'b0;
            drain_wait = 1'b0;
        end
        else
        begin
            offer = 1'b0;
            just_popped = 1'b0;
            if (text.valid && text.ready)
                have_item = 1'b0;
            if (!have_item && text_q.size() != 0)
            begin
                cur_item = text_q.pop_front();
                have_item = 1'b1;
                drain_wait = cur_item.drain;
                just_popped = 1'b1;
            end
            if (have_item)
            begin
                if (drain_wait && !just_popped && results_drained)
                    drain_wait = 1'b0;
                if (drain_wait)
                    offer = 1'b0;
                else if (cur_item.gap > 0)
                    cur_item.gap--;
                else
                    offer = 1'b1;
            end
            send_valid <= offer;
            send_byte <= cur_item.data;
            send_eot <= cur_item.eot;
        end
    end

    // Long hold-off on the result side while the sender keeps offering.
    int hold_left = 0;
    bit hold_done = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_off <= 1'b0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            if (hold_left == 0)
                hold_off <= 1'b0;
        end
        else if (!hold_done && items_accepted >= 62)
        begin
            hold_done = 1'b1;
            hold_left = 300;
            hold_off <= 1'b1;
        end
    end

    int stall_left = 0;
    int results_taken = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            take_ready <= 1'b0;
            stall_left = 0;
            results_taken = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                results_taken++;
                stall_left = ((results_taken / 80) % 3 == 1) ? 0 : $urandom_range(0, 18);
            end
            if (hold_off)
                take_ready <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                take_ready <= 1'b0;
            end
            else
                take_ready <= 1'b1;
        end
    end

    clean_byte_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            close_seq();
            items_accepted <= 0;
            results_drained <= 1'b1;
        end
        else
        begin
            if (text.valid && text.ready)
            begin
                predict_clean(text.in_byte, text.end_of_text);
                items_accepted <= items_accepted + 1;
            end
            if (result.valid && result.ready)
            begin
                if (cleaned_q.size() == 0)
                    report_mismatch($sformatf("unexpected result transaction, byte %02h",
                                              result.out_byte));
                else
                begin
                    want = cleaned_q.pop_front();
                    if (result.out_byte !== want.out_byte)
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  result.out_byte, want.out_byte));
                    if (result.run_last !== want.run_last)
                        report_mismatch($sformatf("run_last %b, expected %b",
                                                  result.run_last, want.run_last));
                    if (result.text_end !== want.text_end)
                        report_mismatch($sformatf("text_end %b, expected %b",
                                                  result.text_end, want.text_end));
                end
            end
            results_drained <= (cleaned_q.size() == 0);
        end
    end

    initial
    begin
        int n_random;
        logic [20:0] cp;
        int i;

        add_text_byte(8'h41, 1'b0);
        add_text_byte(8'h00, 1'b1);
        add_text_byte(8'hC3, 1'b0);
        add_text_byte(8'hA9, 1'b0);
        add_text_byte(8'h80, 1'b0);
        add_text_byte(8'hFF, 1'b0);
        add_text_byte(8'hE4, 1'b0);
        add_text_byte(8'hB8, 1'b0);
        add_text_byte(8'hAD, 1'b0);
        // Overlong three-byte form.
        add_text_byte(8'hE0, 1'b0);
        add_text_byte(8'h9F, 1'b0);
        // Bad continuation after three buffered bytes.
        add_text_byte(8'hF0, 1'b0);
        add_text_byte(8'h9F, 1'b0);
        add_text_byte(8'h98, 1'b0);
        add_text_byte(8'h41, 1'b0);
        add_text_byte(8'hF4, 1'b0);
        add_text_byte(8'h8F, 1'b0);
        add_text_byte(8'hBF, 1'b0);
        add_text_byte(8'hBF, 1'b0);
        // Truncation at the end of the text.
        add_text_byte(8'hE4, 1'b0);
        add_text_byte(8'hB8, 1'b1);
        // Flush of three bytes, then a new lead cut off by the end of the text.
        add_text_byte(8'hF0, 1'b0);
        add_text_byte(8'h9F, 1'b0);
        add_text_byte(8'h98, 1'b0);
        add_text_byte(8'hE4, 1'b1);

        n_random = text_q.size() + 480;
        while (text_q.size() < n_random)
        begin
            i = $urandom_range(0, 99);
            if (i < 68)
                add_codepoint(pick_codepoint(), 0, 0);
            else if (i < 84)
                add_text_byte(8'($urandom_range(0, 255)), rand_eot());
            else
            begin
                cp = pick_codepoint() | 21'h80;
                case ($urandom_range(0, 4))
                    0: add_codepoint(cp, $urandom_range(1, 3), 0);
                    1: add_codepoint(cp, 0, $urandom_range(1, 3));
                    2:
                    begin
                        add_text_byte(8'hED, rand_eot());
                        add_text_byte(8'($urandom_range('hA0, 'hBF)), rand_eot());
                        add_text_byte(8'($urandom_range('h80, 'hBF)), rand_eot());
                    end
                    3:
                    begin
                        add_text_byte(8'hE0, rand_eot());
                        add_text_byte(8'($urandom_range('h80, 'h9F)), rand_eot());
                        add_text_byte(8'($urandom_range('h80, 'hBF)), rand_eot());
                    end
                    default:
                    begin
                        add_text_byte(8'hF4, rand_eot());
                        add_text_byte(8'($urandom_range('h90, 'hBF)), rand_eot());
                        add_text_byte(8'($urandom_range('h80, 'hBF)), rand_eot());
                        add_text_byte(8'($urandom_range('h80, 'hBF)), rand_eot());
                    end
                endcase
            end
        end
        item_total = text_q.size();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (items_accepted == item_total && results_drained);
        repeat (20) @(posedge clk);
        if (cleaned_q.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived", cleaned_q.size()));
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+src
src/utsan_pkg.sv
src/utsan_in_if.sv
src/utsan_out_if.sv
src/utsan_decode.sv
src/utsan_outbuf.sv
src/utf8_text_sanitizer_top.sv
bench/tb.sv
